// File: hdl/sbac_pkg.sv
// Shared types, constants and the arctangent table for the servo bearing block.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package sbac_pkg;

  // Number of micro-rotations requested, and the table limit
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_ROT       = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int IDX_W         = $clog2(TABLE_LEN);

  // Field widths
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 15;
  localparam int CFG_W   = 16;

  // Datapath widths: coordinates are pre-scaled by 2^PRE_SHIFT; vector growth
  // stays below 2^26, the angle sum (2^-16 degree) below 2^23.
  localparam int PRE_SHIFT = 8;
  localparam int XW        = 28;
  localparam int ZW        = 25;

  // Output rounding: 2^-16 degree down to 1/128 degree, round half up
  localparam int FRAC_SHIFT  = 9;
  localparam int ROUND_BIAS  = 256;
  localparam int ANGLE_LIMIT = 11520;

  // Register indexes on the configuration port
  localparam logic CFG_MOUNT_X = 1'b0;
  localparam logic CFG_MOUNT_Y = 1'b1;

  // Item as it moves down the pipeline
  typedef struct packed {
    logic signed [XW-1:0]      x;
    logic signed [XW-1:0]      y;
    logic signed [ZW-1:0]      z;
    logic                      use_cordic;  // 0: fix_angle is the answer
    logic signed [ANGLE_W-1:0] fix_angle;
    logic                      clamped;
  } pipe_t;

  // atan(2^-i) in units of 2^-16 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = ZW'(2949120);
      5'd1:    v = ZW'(1740967);
      5'd2:    v = ZW'(919879);
      5'd3:    v = ZW'(466945);
      5'd4:    v = ZW'(234379);
      5'd5:    v = ZW'(117304);
      5'd6:    v = ZW'(58666);
      5'd7:    v = ZW'(29335);
      5'd8:    v = ZW'(14668);
      5'd9:    v = ZW'(7334);
      5'd10:   v = ZW'(3667);
      5'd11:   v = ZW'(1833);
      5'd12:   v = ZW'(917);
      5'd13:   v = ZW'(458);
      5'd14:   v = ZW'(229);
      5'd15:   v = ZW'(115);
      5'd16:   v = ZW'(57);
      5'd17:   v = ZW'(29);
      5'd18:   v = ZW'(14);
      5'd19:   v = ZW'(7);
      5'd20:   v = ZW'(4);
      5'd21:   v = ZW'(2);
      5'd22:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/sbac_front.sv
// Front stage: offset subtraction, special-case sorting, CORDIC seeding.
// Depends on sbac_pkg.
`timescale 1ns / 1ps

module sbac_front
  import sbac_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] target_x,
  input  logic signed [COORD_W-1:0] target_y,
  input  logic                      target_valid,
  input  logic signed [COORD_W-1:0] mount_x,
  input  logic signed [COORD_W-1:0] mount_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pipe_t                     out_data
);

  localparam logic signed [ANGLE_W-1:0] LIM_POS = ANGLE_W'(ANGLE_LIMIT);
  localparam logic signed [ANGLE_W-1:0] LIM_NEG = ANGLE_W'(-ANGLE_LIMIT);

  logic signed [COORD_W-1:0] dx;
  logic signed [COORD_W-1:0] dy;
  pipe_t                     data_nxt;
  pipe_t                     data_r;
  logic                      valid_r;

  // Differences wrap to 16 bits
  assign dx = target_x - mount_x;
  assign dy = target_y - mount_y;

  // Sort into the fixed answers and the CORDIC case
  always_comb begin
    data_nxt            = '0;
    data_nxt.x          = $signed({{(XW-COORD_W-PRE_SHIFT){dy[COORD_W-1]}}, dy,
                                   {PRE_SHIFT{1'b0}}});
    data_nxt.y          = $signed({{(XW-COORD_W-PRE_SHIFT){dx[COORD_W-1]}}, dx,
                                   {PRE_SHIFT{1'b0}}});
    data_nxt.z          = '0;
    data_nxt.use_cordic = 1'b0;
    data_nxt.fix_angle  = '0;
    data_nxt.clamped    = 1'b0;
    if (!target_valid) begin
      data_nxt.x = '0;
      data_nxt.y = '0;
    end else if (dy < 0) begin
      // target behind: pinned to the side, dx of zero counts as +180
      data_nxt.clamped   = 1'b1;
      data_nxt.fix_angle = (dx >= 0) ? LIM_POS : LIM_NEG;
    end else if (dy == 0) begin
      // lateral axis: exactly +/-90 is in range
      if (dx > 0) begin
        data_nxt.fix_angle = LIM_POS;
      end else if (dx < 0) begin
        data_nxt.fix_angle = LIM_NEG;
      end
    end else begin
      data_nxt.use_cordic = 1'b1;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/sbac_stage.sv
// One registered CORDIC micro-rotation in vectoring mode.
// Depends on sbac_pkg (pipe_t, atan_lut).
`timescale 1ns / 1ps

module sbac_stage
  import sbac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] stage_idx,
  input  logic             in_valid,
  output logic             in_ready,
  input  pipe_t            in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pipe_t            out_data
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] step_angle;
  pipe_t                data_nxt;
  pipe_t                data_r;
  logic                 valid_r;

  // Arithmetic shifts floor, as the rotation needs
  assign xs         = in_data.x >>> stage_idx;
  assign ys         = in_data.y >>> stage_idx;
  assign step_angle = atan_lut(stage_idx);

  // Rotate toward the +x axis
  always_comb begin
    data_nxt = in_data;
    if (in_data.y >= 0) begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + step_angle;
    end else begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - step_angle;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/sbac_back.sv
// Back stage: rounds the angle sum, saturates, picks the fixed answer.
// Holds the output register. Depends on sbac_pkg.
`timescale 1ns / 1ps

module sbac_back
  import sbac_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pipe_t                     in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ANGLE_W-1:0] angle_fixed,
  output logic                      was_clamped
);

  localparam logic signed [ZW:0] LIM_POS_W = (ZW+1)'(ANGLE_LIMIT);
  localparam logic signed [ZW:0] LIM_NEG_W = (ZW+1)'(-ANGLE_LIMIT);

  logic signed [ZW:0]        z_round;
  logic signed [ZW:0]        z_q;
  logic signed [ANGLE_W-1:0] angle_nxt;
  logic signed [ANGLE_W-1:0] angle_r;
  logic                      clamped_r;
  logic                      valid_r;

  // Round half up to 1/128 degree
  assign z_round = $signed({in_data.z[ZW-1], in_data.z}) + (ZW+1)'(ROUND_BIAS);
  assign z_q     = z_round >>> FRAC_SHIFT;

  // Saturate CORDIC overshoot, otherwise take the fixed answer
  always_comb begin
    if (!in_data.use_cordic) begin
      angle_nxt = in_data.fix_angle;
    end else if (z_q > LIM_POS_W) begin
      angle_nxt = ANGLE_W'(ANGLE_LIMIT);
    end else if (z_q < LIM_NEG_W) begin
      angle_nxt = ANGLE_W'(-ANGLE_LIMIT);
    end else begin
      angle_nxt = z_q[ANGLE_W-1:0];
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      angle_r   <= angle_nxt;
      clamped_r <= in_data.clamped;
    end
  end

  assign out_valid   = valid_r;
  assign angle_fixed = angle_r;
  assign was_clamped = clamped_r;

endmodule

// File: hdl/servo_bearing_atan2_clamp_top.sv
// Top level of the servo bearing block: offset registers and the pipeline.
// Depends on sbac_pkg, sbac_front, sbac_stage, sbac_back.
//
//   channel  direction  ports                          payload
//   in_      slave      in_tvalid/in_tready/in_tdata   target_x, target_y; tuser target_valid
//   out_     master     out_tvalid/out_tready/out_tdata angle_fixed; tuser was_clamped
//   cfg_     write      cfg_we/cfg_index/cfg_wdata     mount x offset (0), mount y offset (1)
//
// One transfer per cycle in and out while out_tready stays high. The pipeline is a front
// register, one register per CORDIC micro-rotation and the output register.
// Every stage has its own valid bit; a stage is loaded
// when it is empty or its successor moves, so bubbles close up under a stall.
// Synchronous active-low reset empties the pipeline and clears the offsets.
`timescale 1ns / 1ps

module servo_bearing_atan2_clamp_top
  import sbac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,    // [15:0] target_x, [31:16] target_y
  input  logic             in_tuser,    // [0] target_valid
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,   // [14:0] angle_fixed, [15] zero
  output logic             out_tuser,   // [0] was_clamped
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic signed [COORD_W-1:0] mount_x_r;
  logic signed [COORD_W-1:0] mount_y_r;
  logic                      p_valid [NUM_ROT+1];
  logic                      p_ready [NUM_ROT+1];
  pipe_t                     p_data  [NUM_ROT+1];
  logic signed [ANGLE_W-1:0] angle_fixed;

  // Offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_x_r <= '0;
      mount_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOUNT_X: mount_x_r <= $signed(cfg_wdata[COORD_W-1:0]);
        CFG_MOUNT_Y: mount_y_r <= $signed(cfg_wdata[COORD_W-1:0]);
        default:     mount_x_r <= mount_x_r;
      endcase
    end
  end

  sbac_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .target_x     ($signed(in_tdata[15:0])),
    .target_y     ($signed(in_tdata[31:16])),
    .target_valid (in_tuser),
    .mount_x      (mount_x_r),
    .mount_y      (mount_y_r),
    .out_valid    (p_valid[0]),
    .out_ready    (p_ready[0]),
    .out_data     (p_data[0])
  );

  // CORDIC micro-rotation chain
  for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
    sbac_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (IDX_W'(k)),
      .in_valid  (p_valid[k]),
      .in_ready  (p_ready[k]),
      .in_data   (p_data[k]),
      .out_valid (p_valid[k+1]),
      .out_ready (p_ready[k+1]),
      .out_data  (p_data[k+1])
    );
  end

  sbac_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (p_valid[NUM_ROT]),
    .in_ready    (p_ready[NUM_ROT]),
    .in_data     (p_data[NUM_ROT]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .angle_fixed (angle_fixed),
    .was_clamped (out_tuser)
  );

  assign out_tdata = {1'b0, angle_fixed};

  // Results stay inside the servo range
  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[14:0]) <= $signed(15'(ANGLE_LIMIT)) &&
                    $signed(out_tdata[14:0]) >= $signed(15'(-ANGLE_LIMIT))))
    else $error("angle outside +/-90 degrees");

  // A clamped result sits on one of the stops
  a_clamp_stop : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[14:0] == 15'(ANGLE_LIMIT) || out_tdata[14:0] == 15'(-ANGLE_LIMIT)))
    else $error("clamp flag without a stop angle");

  // With the output register empty the whole chain can move
  a_ready_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  // An accepted item reaches the front register
  a_front_load : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> p_valid[0])
    else $error("accepted transfer lost at the front stage");

endmodule
